// File: rtl/core/hduart_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hduart_pkg
// Types and constants shared by the half-duplex UART with receive stack.
// ----------------------------------------------------------------------------
package hduart_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_PERIOD = 1'b1;

  localparam logic [15:0] BIT_PERIOD_RST      = 16'd104;
  localparam logic [14:0] HALF_BIT_PERIOD_RST = 15'd52;

  // start bit + 8 data bits + stop bit
  localparam logic [3:0] FRAME_BITS = 4'd10;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SEND = 2'd1,
    OP_POP  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       rxd_level;
    logic [7:0] send_byte;
  } in_item_t;

  typedef struct packed {
    logic              txd_level;
    logic              tx_busy;
    logic              rx_busy;
    logic              send_refused;
    logic              rx_pushed;
    logic              frame_error;
    logic              rx_dropped;
    logic              pop_valid;
    logic [7:0]        pop_byte;
    logic [FILL_W-1:0] stack_count;
  } out_item_t;

endpackage

// File: rtl/core/hduart_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hduart_if
// Valid/ready channels for tick transactions and result transactions.
// ----------------------------------------------------------------------------
interface hduart_in_if
  import hduart_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hduart_out_if
  import hduart_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/half_duplex_uart_with_lifo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_uart_with_lifo_unit
// Half-duplex 8N1 UART stepped by tick transactions, with a LIFO byte stack.
// Latency: the result of a tick is registered and presented in the cycle after its acceptance.
// Throughput: one tick per cycle; the stack RAM read is registered and
// overlaps with the next tick. A tick is taken while the result register
// is empty or being emptied in the same cycle.
// Reset: synchronous; control state cleared, stack RAM left as is (fill = 0).
// ----------------------------------------------------------------------------
module half_duplex_uart_with_lifo_unit
  import hduart_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hduart_in_if.sink             tick,
  hduart_out_if.source          result
);

  logic [15:0] bit_period;
  logic [14:0] half_bit_period;

  mode_t       mode, mode_next;
  logic [15:0] bit_timer, bit_timer_next;
  logic [3:0]  bits_left, bits_left_next;
  logic [8:0]  tx_shift, tx_shift_next;
  logic [9:0]  rx_shift, rx_shift_next;
  logic        line_out, line_out_next;
  logic        last_rxd;
  logic [FILL_W-1:0] stack_fill, stack_fill_next;

  logic [7:0] stack_mem [STACK_DEPTH];
  logic [7:0] rd_data;

  logic      res_valid;
  out_item_t res, res_next;

  logic        take;
  logic        was_idle, rx_edge, start_tx, ev;
  logic [3:0]  bl_dec;
  logic [9:0]  rx_new;
  logic        rx_done, rx_good;
  logic        pop_hit, push_ok;
  logic [FILL_W-1:0] fill_pop;

  assign tick.ready = !res_valid || result.ready;
  assign take       = tick.valid && tick.ready;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period      <= BIT_PERIOD_RST;
      half_bit_period <= HALF_BIT_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_PERIOD:      bit_period      <= cfg_wdata;
        REG_HALF_BIT_PERIOD: half_bit_period <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign was_idle = (mode == MODE_IDLE);
  assign rx_edge  = was_idle && last_rxd && !tick.data.rxd_level;
  assign start_tx = (tick.data.opcode == OP_SEND) && was_idle && !rx_edge;
  assign ev       = (bit_timer <= 16'd1);
  assign bl_dec   = (bits_left != 4'd0) ? bits_left - 4'd1 : 4'd0;
  assign rx_new   = {tick.data.rxd_level, rx_shift[9:1]};
  assign rx_done  = (mode == MODE_RX) && ev && (bl_dec == 4'd0);
  assign rx_good  = rx_new[9] && !rx_new[0];
  assign pop_hit  = (tick.data.opcode == OP_POP) && (stack_fill != '0);
  assign fill_pop = pop_hit ? stack_fill - FILL_W'(1) : stack_fill;
  assign push_ok  = rx_done && rx_good && (fill_pop < FILL_W'(STACK_DEPTH));
  assign stack_fill_next = push_ok ? fill_pop + FILL_W'(1) : fill_pop;

  // next mode
  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_TX: if (ev && bl_dec == 4'd0) mode_next = MODE_IDLE;
      MODE_RX: if (rx_done) mode_next = MODE_IDLE;
      default: mode_next = MODE_IDLE;
    endcase
    if (rx_edge) mode_next = MODE_RX;
    else if (start_tx) mode_next = MODE_TX;
  end

  // datapath
  always_comb begin
    bit_timer_next = bit_timer;
    bits_left_next = bits_left;
    tx_shift_next  = tx_shift;
    rx_shift_next  = rx_shift;
    line_out_next  = line_out;
    if (mode != MODE_IDLE) begin
      bit_timer_next = ev ? bit_period : bit_timer - 16'd1;
      if (ev) bits_left_next = bl_dec;
    end
    if (mode == MODE_TX && ev) begin
      if (bits_left >= FRAME_BITS) begin
        line_out_next = 1'b0;
      end else begin
        line_out_next = tx_shift[0];
        tx_shift_next = {1'b0, tx_shift[8:1]};
      end
    end
    if (mode == MODE_RX && ev) rx_shift_next = rx_new;
    if (rx_edge || start_tx) begin
      bits_left_next = FRAME_BITS;
      bit_timer_next = {1'b0, half_bit_period};
    end
    if (rx_edge) rx_shift_next = '0;
    if (start_tx) tx_shift_next = {1'b1, tick.data.send_byte};
  end

  always_comb begin
    res_next.txd_level    = line_out_next;
    res_next.tx_busy      = (mode_next == MODE_TX);
    res_next.rx_busy      = (mode_next == MODE_RX);
    res_next.send_refused = (tick.data.opcode == OP_SEND) && !start_tx;
    res_next.rx_pushed    = push_ok;
    res_next.frame_error  = rx_done && !rx_good;
    res_next.rx_dropped   = rx_done && rx_good && !push_ok;
    res_next.pop_valid    = pop_hit;
    res_next.pop_byte     = '0;
    res_next.stack_count  = stack_fill_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      bit_timer  <= '0;
      bits_left  <= '0;
      tx_shift   <= '0;
      rx_shift   <= '0;
      line_out   <= 1'b1;
      last_rxd   <= 1'b1;
      stack_fill <= '0;
    end else if (take) begin
      mode       <= mode_next;
      bit_timer  <= bit_timer_next;
      bits_left  <= bits_left_next;
      tx_shift   <= tx_shift_next;
      rx_shift   <= rx_shift_next;
      line_out   <= line_out_next;
      last_rxd   <= tick.data.rxd_level;
      stack_fill <= stack_fill_next;
    end
  end

  // stack RAM, read-before-write on the same entry
  always_ff @(posedge clk) begin
    if (take && push_ok) stack_mem[fill_pop[STACK_AW-1:0]] <= rx_new[8:1];
    if (take && pop_hit) rd_data <= stack_mem[fill_pop[STACK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

  assign result.valid = res_valid;
  always_comb begin
    result.data          = res;
    result.data.pop_byte = res.pop_valid ? rd_data : 8'd0;
  end

  assert property (@(posedge clk) disable iff (rst)
    stack_fill <= FILL_W'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $onehot0({result.data.rx_pushed, result.data.frame_error,
                               result.data.rx_dropped}))
    else $error("more than one frame outcome in one transaction");

  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.data.tx_busy && result.data.rx_busy))
    else $error("transmit and receive active together");

  assert property (@(posedge clk) disable iff (rst)
    (take && push_ok) |=> (stack_fill != '0))
    else $error("push left stack empty");

endmodule
